[rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg - shared types and constants of the priority thread scheduler
// Thread status codes, event codes, sequencer states, payload structs and
// the control/status structs passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

   localparam int MAX_THREADS = 8;
   localparam int IDX_W       = $clog2(MAX_THREADS);
   localparam int CNT_W       = $clog2(MAX_THREADS + 1);

   typedef logic [IDX_W-1:0] tid_type;
   typedef logic [CNT_W-1:0] tcnt_type;

   typedef enum logic [1:0] {
      TS_READY    = 2'd0,
      TS_RUNNING  = 2'd1,
      TS_SLEEPING = 2'd2,
      TS_ENDED    = 2'd3
   } thr_state_type;

   typedef enum logic [2:0] {
      FN_TICK   = 3'd0,
      FN_SECOND = 3'd1,
      FN_YIELD  = 3'd2,
      FN_SLEEP  = 3'd3,
      FN_CREATE = 3'd4,
      FN_END    = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DISPATCH,
      SEQ_MUL,
      SEQ_SLEEP,
      SEQ_WAKE,
      SEQ_FIND,
      SEQ_COMMIT,
      SEQ_RESP
   } seq_state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] sleep_ticks;
      logic [2:0]  query_thread;
   } req_type;

   typedef struct packed {
      logic [2:0]  current_thread;
      logic [2:0]  previous_thread;
      logic        switched;
      logic        idle;
      logic [3:0]  thread_total;
      logic        create_rejected;
      logic [15:0] query_run_count;
      logic [15:0] total_run_count;
   } rsp_type;

   // sequencer to datapath
   typedef struct packed {
      logic    take;
      logic    dispatch;
      logic    mul;
      logic    sleep_wr;
      logic    wake;
      logic    find;
      logic    commit;
      logic    load;
      logic    last;
      tid_type idx;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      func_type func;
      logic     ticks_zero;
      logic     cur_running;
      logic     hit;
      logic     rsp_free;
   } sts_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

[rtl/priority_thread_scheduler_top.sv]
// ----------------------------------------------------------------------------
// priority_thread_scheduler_top - fixed-priority thread scheduler
// Keeps thread status, wake times and run counts; each event updates them
// and may select the lowest-index ready or running thread.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one event per transfer (func, sleep_ticks, query_thread).
//   req_stall is high from the accepting edge until the result is loaded,
//   so events are handled one at a time.
//   rsp channel: one result per event, held in an output register; while
//   the receiver stalls, the result holds and the block finishes no event.
//   csr port: tick_step, to be written only while the block is idle; the
//   block itself does not enforce this, the user must keep to it.
// Steps from the accepting edge to rsp_valid, per event:
//   tick: dispatch, wake scan of all entries, selection scan (+commit), load
//   sleep on a running thread: a multiply and store after the dispatch
//   others: dispatch, selection scan (+commit), load
//   The wake and selection scans check one entry per cycle; a new event
//   is taken only once the result of the last one is loaded.
// Reset: thread 0 running, all others ended, counters and time zero,
//   tick_step one.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_thread_scheduler_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pts_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pts_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data
);

   localparam int N = pts_pkg::MAX_THREADS;

   pts_pkg::ctl_type       ctl;
   pts_pkg::sts_type       sts;
   logic                   busy;

   logic [7:0]             tick_step_ff;
   pts_pkg::req_type       req_ff;
   pts_pkg::thr_state_type thread_state_ff [N];
   logic [31:0]            wake_time_ff [N];
   logic [15:0]            runs_now_ff [N];
   logic [15:0]            runs_last_ff [N];
   pts_pkg::tid_type       running_ff;
   pts_pkg::tid_type       prev_ff;
   pts_pkg::tid_type       next_ff;
   pts_pkg::tcnt_type      count_ff;
   logic [31:0]            millis_ff;
   logic [15:0]            all_now_ff;
   logic [15:0]            all_last_ff;
   logic [23:0]            prod_ff;
   logic                   switched_ff;
   logic                   rejected_ff;
   logic                   idle_ff;
   logic                   rsp_valid_ff;
   pts_pkg::rsp_type       rsp_data_ff;

   logic [31:0]            alu_a, alu_b, alu_sum;
   logic                   alu_le;
   pts_pkg::func_type      func;
   logic                   in_table;
   logic                   wake_hit;
   logic                   find_hit;
   logic                   query_ok;
   pts_pkg::thr_state_type scan_state;

   assign func       = pts_pkg::func_type'(req_ff.func);
   assign scan_state = thread_state_ff[ctl.idx];
   assign in_table   = (pts_pkg::tcnt_type'(ctl.idx) < count_ff);
   assign wake_hit   = in_table && (scan_state == pts_pkg::TS_SLEEPING) && alu_le;
   assign find_hit   = in_table && ((scan_state == pts_pkg::TS_READY) ||
                                    (scan_state == pts_pkg::TS_RUNNING));
   assign query_ok   = ({2'b00, req_ff.query_thread} < 5'(N));

   // shared unit operand select
   always_comb begin
      alu_a = millis_ff;
      alu_b = {24'd0, tick_step_ff};
      if (ctl.wake) begin
         alu_a = wake_time_ff[ctl.idx];
         alu_b = millis_ff;
      end else if (ctl.sleep_wr) begin
         alu_b = {8'd0, prod_ff};
      end
   end

   pts_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sum (alu_sum),
      .le  (alu_le)
   );

   assign sts.func        = func;
   assign sts.ticks_zero  = (req_ff.sleep_ticks == 16'd0);
   assign sts.cur_running = (thread_state_ff[running_ff] == pts_pkg::TS_RUNNING);
   assign sts.hit         = ctl.find && find_hit;
   assign sts.rsp_free    = !rsp_valid_ff || !rsp_stall;

   pts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .busy      (busy),
      .ctl       (ctl)
   );

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // payload capture, multiply and capture of the selected thread index
   always_ff @(posedge clock) begin
      if (ctl.take) begin
         req_ff <= req_data;
      end
      if (ctl.mul) begin
         prod_ff <= req_ff.sleep_ticks * tick_step_ff;
      end
      if (ctl.find && find_hit) begin
         next_ff <= ctl.idx;
      end
   end

   // thread table and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            thread_state_ff[i] <= (i == 0) ? pts_pkg::TS_RUNNING : pts_pkg::TS_ENDED;
            wake_time_ff[i]    <= '0;
            runs_now_ff[i]     <= '0;
            runs_last_ff[i]    <= '0;
         end
         tick_step_ff <= 8'd1;
         running_ff   <= '0;
         prev_ff      <= '0;
         count_ff     <= pts_pkg::tcnt_type'(1);
         millis_ff    <= '0;
         all_now_ff   <= '0;
         all_last_ff  <= '0;
         switched_ff  <= 1'b0;
         rejected_ff  <= 1'b0;
         idle_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tick_step_ff <= csr_wr_data;
         end
         if (ctl.dispatch) begin
            prev_ff     <= running_ff;
            switched_ff <= 1'b0;
            rejected_ff <= 1'b0;
            case (func)
               pts_pkg::FN_TICK: begin
                  millis_ff <= alu_sum;
               end
               pts_pkg::FN_SECOND: begin
                  for (int i = 0; i < N; i++) begin
                     runs_last_ff[i] <= runs_now_ff[i];
                     runs_now_ff[i]  <= '0;
                  end
                  all_last_ff <= all_now_ff;
                  all_now_ff  <= '0;
               end
               pts_pkg::FN_CREATE: begin
                  if (count_ff >= pts_pkg::tcnt_type'(N)) begin
                     rejected_ff <= 1'b1;
                  end else begin
                     thread_state_ff[count_ff[pts_pkg::IDX_W-1:0]] <= pts_pkg::TS_READY;
                     wake_time_ff[count_ff[pts_pkg::IDX_W-1:0]]    <= '0;
                     runs_now_ff[count_ff[pts_pkg::IDX_W-1:0]]     <= '0;
                     runs_last_ff[count_ff[pts_pkg::IDX_W-1:0]]    <= '0;
                     count_ff <= count_ff + 1'b1;
                  end
               end
               pts_pkg::FN_END: begin
                  thread_state_ff[running_ff] <= pts_pkg::TS_ENDED;
               end
               default: begin
                  switched_ff <= 1'b0;
               end
            endcase
         end
         if (ctl.sleep_wr) begin
            wake_time_ff[running_ff]    <= alu_sum;
            thread_state_ff[running_ff] <= pts_pkg::TS_SLEEPING;
         end
         if (ctl.wake && wake_hit) begin
            wake_time_ff[ctl.idx]    <= '0;
            thread_state_ff[ctl.idx] <= pts_pkg::TS_READY;
         end
         if (ctl.find) begin
            if (find_hit) begin
               idle_ff <= 1'b0;
            end else if (ctl.last) begin
               idle_ff <= 1'b1;
            end
         end
         if (ctl.commit) begin
            runs_now_ff[next_ff] <= pts_pkg::sat_inc(runs_now_ff[next_ff]);
            all_now_ff           <= pts_pkg::sat_inc(all_now_ff);
            if (next_ff != running_ff) begin
               // old thread goes back to ready only if it was still running
               if (thread_state_ff[running_ff] == pts_pkg::TS_RUNNING) begin
                  thread_state_ff[running_ff] <= pts_pkg::TS_READY;
               end
               thread_state_ff[next_ff] <= pts_pkg::TS_RUNNING;
               running_ff               <= next_ff;
               switched_ff              <= 1'b1;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_data_ff.current_thread  <= 3'(running_ff);
         rsp_data_ff.previous_thread <= 3'(prev_ff);
         rsp_data_ff.switched        <= switched_ff;
         rsp_data_ff.idle            <= idle_ff;
         rsp_data_ff.thread_total    <= 4'(count_ff);
         rsp_data_ff.create_rejected <= rejected_ff;
         rsp_data_ff.query_run_count <= query_ok ?
            runs_last_ff[pts_pkg::tid_type'(req_ff.query_thread)] : 16'd0;
         rsp_data_ff.total_run_count <= all_last_ff;
      end
   end

endmodule

`default_nettype wire

[rtl/pts_alu.sv]
// ----------------------------------------------------------------------------
// pts_alu - shared 32-bit add and compare unit
// Used for the millisecond advance, the sleep deadline and each wake check.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_alu (
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [31:0] sum,
   output logic             le
);

   assign sum = a + b;
   assign le  = (a <= b);

endmodule

`default_nettype wire

[rtl/pts_seq.sv]
// ----------------------------------------------------------------------------
// pts_seq - event sequencer of the priority thread scheduler
// Steps one event through dispatch, the sleep multiply and store, the wake
// and selection scans, one thread entry per cycle, the commit and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_seq (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire pts_pkg::sts_type sts,
   output logic                 busy,
   output pts_pkg::ctl_type     ctl
);

   pts_pkg::seq_state_type state_ff, state_in;
   pts_pkg::tid_type       idx_ff, idx_in;
   logic                   sel_ff, sel_in;
   logic                   last;

   assign last = (idx_ff == pts_pkg::tid_type'(pts_pkg::MAX_THREADS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sel_in   = sel_ff;
      case (state_ff)
         pts_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               state_in = pts_pkg::SEQ_DISPATCH;
            end
         end
         pts_pkg::SEQ_DISPATCH: begin
            idx_in   = '0;
            state_in = pts_pkg::SEQ_FIND;
            case (sts.func)
               pts_pkg::FN_TICK: begin
                  state_in = pts_pkg::SEQ_WAKE;
               end
               pts_pkg::FN_YIELD: begin
                  sel_in = 1'b1;
               end
               pts_pkg::FN_SLEEP: begin
                  if (sts.ticks_zero) begin
                     sel_in = 1'b0;
                  end else if (sts.cur_running) begin
                     state_in = pts_pkg::SEQ_MUL;
                  end else begin
                     sel_in = 1'b1;
                  end
               end
               pts_pkg::FN_END: begin
                  sel_in = 1'b1;
               end
               default: begin
                  sel_in = 1'b0;
               end
            endcase
         end
         pts_pkg::SEQ_MUL: begin
            state_in = pts_pkg::SEQ_SLEEP;
         end
         pts_pkg::SEQ_SLEEP: begin
            sel_in   = 1'b1;
            state_in = pts_pkg::SEQ_FIND;
         end
         pts_pkg::SEQ_WAKE: begin
            if (last) begin
               idx_in   = '0;
               sel_in   = 1'b1;
               state_in = pts_pkg::SEQ_FIND;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pts_pkg::SEQ_FIND: begin
            if (sts.hit) begin
               state_in = sel_ff ? pts_pkg::SEQ_COMMIT : pts_pkg::SEQ_RESP;
            end else if (last) begin
               state_in = pts_pkg::SEQ_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pts_pkg::SEQ_COMMIT: begin
            state_in = pts_pkg::SEQ_RESP;
         end
         pts_pkg::SEQ_RESP: begin
            if (sts.rsp_free) begin
               state_in = pts_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = pts_pkg::SEQ_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl          = '0;
      ctl.idx      = idx_ff;
      ctl.last     = last;
      busy         = (state_ff != pts_pkg::SEQ_IDLE);
      case (state_ff)
         pts_pkg::SEQ_IDLE:     ctl.take     = req_valid;
         pts_pkg::SEQ_DISPATCH: ctl.dispatch = 1'b1;
         pts_pkg::SEQ_MUL:      ctl.mul      = 1'b1;
         pts_pkg::SEQ_SLEEP:    ctl.sleep_wr = 1'b1;
         pts_pkg::SEQ_WAKE:     ctl.wake     = 1'b1;
         pts_pkg::SEQ_FIND:     ctl.find     = 1'b1;
         pts_pkg::SEQ_COMMIT:   ctl.commit   = 1'b1;
         pts_pkg::SEQ_RESP:     ctl.load     = sts.rsp_free;
         default:               ctl.take     = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pts_pkg::SEQ_IDLE;
         idx_ff   <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

`default_nettype wire
